/* sv/spl_pkg.sv */
// ----------------------------------------------------------------------------
// spl_pkg - shared types and constants
// Formats, digit size and sequencer codes for the stereo pre-emphasis and
// low-pass filter.
// ----------------------------------------------------------------------------
`default_nettype none

package spl_pkg;

  // Default sample width, Q1.(SAMPLE_WIDTH-1)
  localparam int SAMPLE_WIDTH = 24;
  // Headroom on the filter state
  localparam int GUARD_BITS   = 8;

  // Register widths and fraction bits
  localparam int GAIN_W       = 32;
  localparam int COEF_W       = 24;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int GAIN_FRAC    = 24;
  localparam int COEF_FRAC    = 22;

  // 1.0 in Q2.22
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);

  // Multiplier digit: one digit of the 32-bit operand per cycle
  localparam int DIGIT_W      = 8;
  localparam int DIGITS       = GAIN_W / DIGIT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN = 3'd0,
    CFG_B0   = 3'd1,
    CFG_B1   = 3'd2,
    CFG_A1   = 3'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_OUT
  } state_t;

  // Products worked per channel, in this order
  typedef enum logic [1:0] {
    OP_DIFF = 2'd0,
    OP_B0   = 2'd1,
    OP_A1   = 2'd2,
    OP_B1   = 2'd3
  } op_t;

  typedef struct packed {
    logic start;
    logic gain_frac;   // scale by the gain fraction, else by the coefficient one
  } spl_mul_ctl_t;

endpackage

`default_nettype wire

/* sv/spl_if.sv */
// ----------------------------------------------------------------------------
// spl_if - stereo word channels
// Valid/ready channels for input and output frames.
// ----------------------------------------------------------------------------
`default_nettype none

interface spl_in_if #(parameter int SW = spl_pkg::SAMPLE_WIDTH);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] left_in;
  logic signed [SW-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface spl_out_if #(parameter int SW = spl_pkg::SAMPLE_WIDTH);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] left_out;
  logic signed [SW-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

/* sv/spl_mul.sv */
// ----------------------------------------------------------------------------
// spl_mul - digit-serial signed multiplier with rounding
// A (signed) times B (signed, 32 bits), one 8-bit digit of B per cycle, LSB
// first. Returns (A*B + half LSB) >>> frac, frac being the gain or coef one.
// ----------------------------------------------------------------------------
`default_nettype none

module spl_mul #(
  parameter int AW = spl_pkg::SAMPLE_WIDTH + spl_pkg::GUARD_BITS,
  parameter int RW = AW + spl_pkg::GAIN_W - spl_pkg::COEF_FRAC + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire spl_pkg::spl_mul_ctl_t         ctl,
  input  wire logic signed [AW-1:0]          a,
  input  wire logic [spl_pkg::GAIN_W-1:0]    b,
  output logic                               done,
  output logic signed [RW-1:0]               res
);

  localparam int DW = spl_pkg::DIGIT_W;
  localparam int BW = spl_pkg::GAIN_W;
  localparam int HW = AW + DW + 2;
  localparam int FW = HW + BW;
  localparam int CW = (spl_pkg::DIGITS > 1) ? $clog2(spl_pkg::DIGITS) : 1;
  localparam int BIAS_GAIN = 1 << (spl_pkg::GAIN_FRAC - 1);
  localparam int BIAS_COEF = 1 << (spl_pkg::COEF_FRAC - 1);

  logic signed [AW-1:0]   a_reg;
  logic [BW-1:0]          b_sh;
  logic signed [HW-1:0]   hi;
  logic [BW-1:0]          lo;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic                   gain_frac;

  logic [DW-1:0]          dig;
  logic                   last;
  logic signed [DW:0]     dig_s;
  logic signed [AW+DW:0]  prod;
  logic signed [HW-1:0]   sum;
  logic [FW-1:0]          full;

  always_comb begin
    dig   = b_sh[DW-1:0];
    last  = (cnt == CW'(spl_pkg::DIGITS - 1));
    // top digit carries the sign of B, the others are unsigned
    dig_s = last ? $signed({dig[DW-1], dig}) : $signed({1'b0, dig});
    prod  = a_reg * dig_s;
    sum   = hi + HW'(prod);
    full  = {hi, lo};
    res   = gain_frac ? $signed(full[spl_pkg::GAIN_FRAC +: RW])
                      : $signed(full[spl_pkg::COEF_FRAC +: RW]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: rounding bias is preloaded at weight 2^0, digits retire into lo
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_reg     <= a;
      b_sh      <= b;
      gain_frac <= ctl.gain_frac;
      hi        <= ctl.gain_frac ? HW'(BIAS_GAIN) : HW'(BIAS_COEF);
      lo        <= '0;
    end else if (busy) begin
      b_sh <= b_sh >> DW;
      lo   <= {sum[DW-1:0], lo[BW-1:DW]};
      hi   <= sum >>> DW;
    end
  end

endmodule

`default_nettype wire

/* sv/stereo_preemphasis_lowpass.sv */
// ----------------------------------------------------------------------------
// stereo_preemphasis_lowpass - stereo pre-emphasis and first-order low-pass
// Per channel: v = sat(x + gain*(x - x_prev)); y = sat(s + b0*v);
// s = sat(a1*y + b1*v); out = sat(y). One shared digit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage
//  din  : stereo input word (left_in, right_in), taken when valid & ready.
//  dout : filtered word (left_out, right_out), held until ready is seen.
//  cfg  : cfg_we/cfg_index/cfg_data write gain (0), b0 (1), b1 (2), a1 (3);
//         other indexes are dropped. Write only while the filter is idle.
// Timing
//  Eight products per word (four per channel), each on the digit-serial
//  multiplier: a load, four 8-bit digits, then round, add and saturate.
//  dout.valid rises when the finished word is loaded; din.ready comes back
//  at the same edge, so the next input word is taken only then.
// Stalls
//  The finished word sits in the output register; the next input word is
//  taken and worked while it waits. Only a second finished word waits for
//  the register to free up (din.ready stays low meanwhile).
// Reset
//  rst (sync, active high) clears the sequencer, output valid, the per
//  channel history and state, and loads gain 0, b0 1.0, b1 0, a1 0.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_preemphasis_lowpass #(
  parameter int SAMPLE_WIDTH = spl_pkg::SAMPLE_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [spl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [spl_pkg::CFG_W-1:0]         cfg_data,
  spl_in_if.sink                                 din,
  spl_out_if.source                              dout
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int W    = SW + spl_pkg::GUARD_BITS;              // state width
  localparam int RW   = W + spl_pkg::GAIN_W - spl_pkg::COEF_FRAC + 1;
  localparam int SUMW = RW + 1;

  localparam logic signed [SUMW-1:0] S_MAX = SUMW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] S_MIN = -S_MAX - SUMW'(1);
  localparam logic signed [SUMW-1:0] W_MAX = SUMW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] W_MIN = -W_MAX - SUMW'(1);

  function automatic logic signed [SW-1:0] sat_s(input logic signed [SUMW-1:0] z);
    logic signed [SUMW-1:0] r;
    r = (z > S_MAX) ? S_MAX : ((z < S_MIN) ? S_MIN : z);
    return r[SW-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_w(input logic signed [SUMW-1:0] z);
    logic signed [SUMW-1:0] r;
    r = (z > W_MAX) ? W_MAX : ((z < W_MIN) ? W_MIN : z);
    return r[W-1:0];
  endfunction

  // Sequencer
  spl_pkg::state_t state, state_next;
  spl_pkg::op_t    op;
  logic            ch;             // 0 left, 1 right

  // Config registers
  logic signed [spl_pkg::GAIN_W-1:0] gain;
  logic signed [spl_pkg::COEF_W-1:0] b0, b1, a1;

  // Per-channel history and filter state
  logic signed [SW-1:0] prev [2];
  logic signed [W-1:0]  acc  [2];
  logic signed [SW-1:0] yout [2];

  // Working registers
  logic signed [SW-1:0] x_l, x_r;
  logic signed [SW-1:0] v;
  logic signed [W-1:0]  y;
  logic signed [RW-1:0] t;

  // Output register
  logic                 out_valid;
  logic signed [SW-1:0] out_l, out_r;

  // Multiplier hookup
  spl_pkg::spl_mul_ctl_t       mul_ctl;
  logic signed [W-1:0]         mul_a;
  logic [spl_pkg::GAIN_W-1:0]  mul_b;
  logic                        mul_done;
  logic signed [RW-1:0]        mul_res;

  logic                 in_ready;
  logic                 out_load;
  logic                 post;
  logic                 in_take;
  logic signed [SW-1:0] x_cur;
  logic signed [SUMW-1:0] sum_post;

  spl_mul #(
    .AW (W),
    .RW (RW)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      spl_pkg::S_IDLE:  if (din.valid) state_next = spl_pkg::S_START;
      spl_pkg::S_START: state_next = spl_pkg::S_WAIT;
      spl_pkg::S_WAIT: begin
        if (mul_done) begin
          state_next = (op == spl_pkg::OP_B1 && ch) ? spl_pkg::S_OUT : spl_pkg::S_START;
        end
      end
      spl_pkg::S_OUT:   if (!out_valid || dout.ready) state_next = spl_pkg::S_IDLE;
      default:          state_next = spl_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready          = (state == spl_pkg::S_IDLE);
    mul_ctl.start     = (state == spl_pkg::S_START);
    mul_ctl.gain_frac = (op == spl_pkg::OP_DIFF);
    post              = (state == spl_pkg::S_WAIT) && mul_done;
    out_load          = (state == spl_pkg::S_OUT) && (!out_valid || dout.ready);
  end

  assign din.ready      = in_ready;
  assign in_take        = din.valid && in_ready;
  assign dout.valid     = out_valid;
  assign dout.left_out  = out_l;
  assign dout.right_out = out_r;

  // Operand select and post-product add
  always_comb begin
    x_cur = ch ? x_r : x_l;
    case (op)
      spl_pkg::OP_DIFF: begin
        mul_a    = W'(x_cur) - W'(prev[ch]);
        mul_b    = gain;
        sum_post = SUMW'(x_cur) + SUMW'(mul_res);
      end
      spl_pkg::OP_B0: begin
        mul_a    = W'(v);
        mul_b    = spl_pkg::GAIN_W'(b0);
        sum_post = SUMW'(acc[ch]) + SUMW'(mul_res);
      end
      spl_pkg::OP_A1: begin
        mul_a    = y;
        mul_b    = spl_pkg::GAIN_W'(a1);
        sum_post = SUMW'(mul_res);
      end
      spl_pkg::OP_B1: begin
        mul_a    = W'(v);
        mul_b    = spl_pkg::GAIN_W'(b1);
        sum_post = SUMW'(t) + SUMW'(mul_res);
      end
      default: begin
        mul_a    = '0;
        mul_b    = '0;
        sum_post = '0;
      end
    endcase
  end

  // Control, config and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spl_pkg::S_IDLE;
      op        <= spl_pkg::OP_DIFF;
      ch        <= 1'b0;
      out_valid <= 1'b0;
      gain      <= '0;
      b0        <= spl_pkg::COEF_ONE;
      b1        <= '0;
      a1        <= '0;
      prev[0]   <= '0;
      prev[1]   <= '0;
      acc[0]    <= '0;
      acc[1]    <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (spl_pkg::cfg_idx_t'(cfg_index))
          spl_pkg::CFG_GAIN: gain <= cfg_data[spl_pkg::GAIN_W-1:0];
          spl_pkg::CFG_B0:   b0   <= cfg_data[spl_pkg::COEF_W-1:0];
          spl_pkg::CFG_B1:   b1   <= cfg_data[spl_pkg::COEF_W-1:0];
          spl_pkg::CFG_A1:   a1   <= cfg_data[spl_pkg::COEF_W-1:0];
          default: ;
        endcase
      end

      if (in_take) begin
        op <= spl_pkg::OP_DIFF;
        ch <= 1'b0;
      end else if (post) begin
        if (op == spl_pkg::OP_B1) begin
          op <= spl_pkg::OP_DIFF;
          ch <= 1'b1;
        end else begin
          op <= spl_pkg::op_t'(op + 2'd1);
        end
      end

      if (post && op == spl_pkg::OP_DIFF) prev[ch] <= x_cur;
      if (post && op == spl_pkg::OP_B1)   acc[ch]  <= sat_w(sum_post);

      if (out_load)        out_valid <= 1'b1;
      else if (dout.ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_l <= din.left_in;
      x_r <= din.right_in;
    end
    if (post) begin
      case (op)
        spl_pkg::OP_DIFF: v <= sat_s(sum_post);
        spl_pkg::OP_B0:   y <= sat_w(sum_post);
        spl_pkg::OP_A1:   t <= mul_res;
        spl_pkg::OP_B1:   yout[ch] <= sat_s(SUMW'(y));
        default: ;
      endcase
    end
    if (out_load) begin
      out_l <= yout[0];
      out_r <= yout[1];
    end
  end

  // Checks
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == spl_pkg::S_WAIT)
    else $error("multiplier finished outside the wait state");

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == spl_pkg::S_START && ch == 1'b0 && op == spl_pkg::OP_DIFF))
    else $error("word taken but sequencer not at left difference product");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("output load did not raise valid");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (state == spl_pkg::S_OUT && out_valid && !dout.ready) |=> !din.ready)
    else $error("input ready while a finished word waits");

endmodule

`default_nettype wire

/* test/tb_stereo_preemphasis_lowpass.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_preemphasis_lowpass - self-checking bench for the stereo filter
// Drives stereo words through the valid/ready input channel, predicts each
// filtered word in-bench and checks every output word field by field, across
// reset, extreme and random filter settings with random stalls on both sides.
// ----------------------------------------------------------------------------

module tb_stereo_preemphasis_lowpass;

  import spl_pkg::*;

  localparam int SW        = SAMPLE_WIDTH;
  localparam int WIDE      = SAMPLE_WIDTH + GUARD_BITS;  // state width, 8 guard bits
  localparam int PERIOD    = 12;
  localparam int HOLD_AT   = 340;   // words in before the long output hold-off
  localparam int HOLD_LEN  = 300;   // cycles of that hold-off
  localparam int SETTLE    = 60;    // a little over the word latency

  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [GAIN_W-1:0]    GAIN_MAX   = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic [GAIN_W-1:0]    GAIN_MIN   = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic [COEF_W-1:0]    COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0]    COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};

  // one stereo word, used for both samples in and filtered words out
  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } frame_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  spl_in_if  #(.SW(SW)) din_if ();
  spl_out_if #(.SW(SW)) dout_if ();

  stereo_preemphasis_lowpass #(.SAMPLE_WIDTH(SW)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .din      (din_if),
    .dout     (dout_if)
  );

  always #(PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: own copy of the filter settings and per-channel history
  // --------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] gain_r;
  logic signed [COEF_W-1:0] b0_r, b1_r, a1_r;
  logic signed [SW-1:0]     last_l, last_r;    // previous raw samples
  logic signed [WIDE-1:0]   acc_l, acc_r;      // section state, Q9.23

  frame_t samples_q[$];    // words waiting to be offered
  frame_t filtered_q[$];   // predicted output words, oldest first

  int words_queued;        // words handed to the driver so far
  int words_in;            // words taken by the filter
  int words_checked;
  int settings_seen;
  int faults;
  int send_idle_pct;
  int take_idle_pct;
  int hold_cnt;
  bit hold_done;

  // round half up: add half an LSB, then floor (>>> on longint is a floor)
  function automatic longint round_q(longint v, int frac);
    return (v + (longint'(1) <<< (frac - 1))) >>> frac;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // pre-emphasis then one transposed DF-II step; history and state updated
  function automatic logic signed [SW-1:0] channel_step(
      input logic signed [SW-1:0]   x,
      inout logic signed [SW-1:0]   last_x,
      inout logic signed [WIDE-1:0] acc);
    longint v;
    longint y;
    v = clamp(longint'(x) +
              round_q((longint'(x) - longint'(last_x)) * longint'(gain_r), GAIN_FRAC), SW);
    // wide y is kept for the feedback path, only the output is cut to SW
    y = clamp(longint'(acc) + round_q(longint'(b0_r) * v, COEF_FRAC), WIDE);
    last_x = x;
    acc = WIDE'(clamp(round_q(longint'(a1_r) * y, COEF_FRAC) +
                      round_q(longint'(b1_r) * v, COEF_FRAC), WIDE));
    return SW'(clamp(y, SW));
  endfunction

  function automatic frame_t emphasise_and_filter(frame_t s);
    frame_t f;
    f.left  = channel_step(s.left,  last_l, acc_l);
    f.right = channel_step(s.right, last_r, acc_r);
    return f;
  endfunction

  task automatic report_fault(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    faults++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [SW-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3, 4: return SW'(int'($urandom_range(0, 65535)) - 32768);  // quiet signal
      default: return SW'($urandom());
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GAIN_W'($urandom());
      2:       return GAIN_MAX;
      3:       return GAIN_MIN;
      default: return GAIN_W'(int'($urandom_range(0, 33554432)) - 16777216);  // |g| <= 1.0
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_W'($urandom());
      1:       return COEF_MAX;
      2:       return COEF_MIN;
      default: return COEF_W'(int'($urandom_range(0, 7549746)) - 3774873);  // |c| < 0.9
    endcase
  endfunction

  task automatic queue_frame(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
    samples_q.push_back('{left: l, right: r});
    words_queued++;
  endtask

  // random words; every fifth or so repeats the last word so the difference is nil
  task automatic queue_random(int n);
    frame_t f;
    f = '0;
    repeat (n) begin
      if ($urandom_range(0, 4) != 0) begin
        f.left  = random_sample();
        f.right = random_sample();
      end
      samples_q.push_back(f);
      words_queued++;
    end
  endtask

  // one register write per clock; the predictor copy follows at once
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_GAIN: gain_r = data[GAIN_W-1:0];
      CFG_B0:   b0_r   = data[COEF_W-1:0];
      CFG_B1:   b1_r   = data[COEF_W-1:0];
      CFG_A1:   a1_r   = data[COEF_W-1:0];
      default: ;  // no such register, dropped
    endcase
  endtask

  // full filter setting; random bits above each coefficient and one stray
  // write to an unused index, neither of which may change anything
  task automatic load_settings(logic [GAIN_W-1:0] g, logic [COEF_W-1:0] b0,
                               logic [COEF_W-1:0] b1, logic [COEF_W-1:0] a1);
    write_reg(CFG_GAIN, CFG_W'(g));
    write_reg(CFG_B0, {8'($urandom()), b0});
    write_reg(CFG_B1, {8'($urandom()), b1});
    write_reg(CFG_A1, {8'($urandom()), a1});
    write_reg(CFG_IDX_W'($urandom_range(int'(CFG_A1) + 1, (1 << CFG_IDX_W) - 1)),
              CFG_W'($urandom()));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  // wait until every queued word has come back out and been checked
  task automatic drain();
    do @(posedge clk);
    while (words_checked < words_queued);
    repeat (2) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: offers the next pending word, holds it until taken.
  // Prediction is made on the edge the word is accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_t nxt;
    if (rst) begin
      din_if.valid <= 1'b0;
    end else begin
      if (din_if.valid && din_if.ready) begin
        filtered_q.push_back(emphasise_and_filter('{left: din_if.left_in,
                                                    right: din_if.right_in}));
        words_in <= words_in + 1;
      end
      // a word still on offer must stay put
      if (!(din_if.valid && !din_if.ready)) begin
        if (samples_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = samples_q.pop_front();
          din_if.valid    <= 1'b1;
          din_if.left_in  <= nxt.left;
          din_if.right_in <= nxt.right;
        end else begin
          din_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long output hold-off, once: the filter fills and must stall its input
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: random back-pressure and the word-by-word check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_t want;
    if (rst) begin
      dout_if.ready <= 1'b0;
    end else begin
      if (dout_if.valid && dout_if.ready) begin
        if (filtered_q.size() == 0) begin
          report_fault($sformatf("output word %h/%h with none expected",
                                 dout_if.left_out, dout_if.right_out));
        end else begin
          want = filtered_q.pop_front();
          if (dout_if.left_out !== want.left)
            report_fault($sformatf("word %0d left_out %h, expected %h",
                                   words_checked, dout_if.left_out, want.left));
          if (dout_if.right_out !== want.right)
            report_fault($sformatf("word %0d right_out %h, expected %h",
                                   words_checked, dout_if.right_out, want.right));
          words_checked++;
        end
      end
      dout_if.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= take_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    settings_seen   = 1;    // reset setting counts as the first
    send_idle_pct   = 16;
    take_idle_pct   = 74;
    // predictor mirrors the reset setting: gain 0, b0 1.0, b1 0, a1 0
    gain_r = '0;
    b0_r   = COEF_ONE;
    b1_r   = '0;
    a1_r   = '0;
    last_l = '0;
    last_r = '0;
    acc_l  = '0;
    acc_r  = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset setting passes samples straight through: field extremes
    queue_frame('0, '0);
    queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    queue_frame(SAMPLE_MIN, SAMPLE_MAX);
    queue_frame(SW'(-1), SW'(1));
    queue_frame(SW'(1), SW'(-1));
    queue_frame('0, '0);
    drain();

    // all-maximum setting: the difference gain clips the pre-emphasis,
    // b0 near 2 clips the output, a1 near 2 runs the state into both
    // wide clamps. Right channel carries the opposite sign.
    load_settings(GAIN_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    queue_frame(SAMPLE_MIN, SAMPLE_MAX);
    queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    queue_frame(SAMPLE_MIN, SAMPLE_MAX);
    repeat (8) queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    drain();

    // all-minimum setting: negative feedback, state swings sign each word
    load_settings(GAIN_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    queue_frame(SAMPLE_MIN, SAMPLE_MAX);
    queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    repeat (4) queue_frame(SAMPLE_MIN, SAMPLE_MAX);
    drain();

    // random settings and words; the idle pattern flips after two settings,
    // then both sides run flat out for the last two (the long hold-off lands there)
    for (phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct <= 74;
        take_idle_pct <= 16;
      end
      if (phase == 4) begin
        send_idle_pct <= 0;
        take_idle_pct <= 0;
      end
      load_settings(random_gain(), random_coef(), random_coef(), random_coef());
      queue_random(65);
      drain();
    end

    // any stray word would show up within the latency
    repeat (SETTLE) @(posedge clk);
    if (filtered_q.size() != 0)
      report_fault($sformatf("%0d filtered words never came out", filtered_q.size()));

    $display("Ran %0d stereo words through %0d filter settings, %0d checked.",
             words_in, settings_seen, words_checked);
    $display("Covered both idle patterns, a %0d-cycle output hold-off and clipping paths.",
             HOLD_LEN);
    if (faults == 0) begin
      $display("** stereo_preemphasis_lowpass: PASSED **");
    end else begin
      $display("** stereo_preemphasis_lowpass: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(PERIOD * 400_000);
    $display("Timed out with %0d words still expected", filtered_q.size());
    $display("** stereo_preemphasis_lowpass: FAILED **");
    $finish;
  end

endmodule
